[rtl/pms_pkg.sv]
// pms_pkg: types, widths and constants for the particle motion step block
// shared by particle_motion_step and pms_iter_unit; no dependencies

package pms_pkg;

    localparam int FRAC_BITS = 16;

    localparam int PIX_W    = 12;
    localparam int POS_W    = 28;
    localparam int VEL_W    = 24;
    localparam int VX_W     = 25;
    localparam int ACC_W    = 19;
    localparam int DIFF_W   = 29;
    localparam int MUL_W    = 28;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SQ_W     = 58;
    localparam int NUM_W    = 59;
    localparam int DEN_W    = 41;
    localparam int QUO_W    = 23;
    localparam int ROOT_W   = SQ_W / 2;
    localparam int AUX_W    = 64;
    localparam int GAIN_W   = 18;
    localparam int DENSUM_W = 25;
    localparam int CNT_W    = 5;
    localparam int WRAP_W   = POS_W + 2;

    localparam logic [PIX_W-1:0] WIDTH_RST  = 12'd1024;
    localparam logic [PIX_W-1:0] HEIGHT_RST = 12'd768;
    localparam logic [22:0]      TOP_RST    = 23'd655360;
    localparam logic [17:0]      CAX_RST    = 18'h3FFBE;
    localparam logic [17:0]      CAY_RST    = 18'd655;

    localparam logic [POS_W-1:0] POS_X_RST = {WIDTH_RST >> 1, {FRAC_BITS{1'b0}}};
    localparam logic [POS_W-1:0] POS_Y_RST = {HEIGHT_RST >> 1, {FRAC_BITS{1'b0}}};
    localparam logic [POS_W-1:0] POS_MAX   = {{PIX_W{1'b1}}, {FRAC_BITS{1'b0}}};

    localparam logic [GAIN_W-1:0] GAIN_HALF  = GAIN_W'(1) << (FRAC_BITS - 1);
    localparam logic [GAIN_W-1:0] GAIN_TWO   = GAIN_W'(2) << FRAC_BITS;
    localparam logic [GAIN_W-1:0] GAIN_THREE = GAIN_W'(3) << FRAC_BITS;

    localparam logic [2:0] MODE_CONST = 3'd0;
    localparam logic [2:0] MODE_EXT   = 3'd1;
    localparam logic [2:0] MODE_SEEK  = 3'd2;
    localparam logic [2:0] MODE_FAR   = 3'd3;
    localparam logic [2:0] MODE_CLOSE = 3'd4;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_TOP    = 3'd2;
    localparam logic [2:0] REG_MODE   = 3'd3;
    localparam logic [2:0] REG_CAX    = 3'd4;
    localparam logic [2:0] REG_CAY    = 3'd5;

    typedef enum logic [0:0] {
        OP_SQRT,
        OP_DIV
    } eng_op_t;

    typedef struct packed {
        logic    start;
        eng_op_t op;
    } eng_req_t;

    typedef struct packed {
        logic busy;
        logic ovf;
    } eng_rsp_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_D2,
        ST_ROOT_D,
        ST_ROOT_D_W,
        ST_WW,
        ST_HH,
        ST_DEN,
        ST_RATIO,
        ST_RATIO_W,
        ST_MUL_AX,
        ST_DIV_AX,
        ST_DIV_AX_W,
        ST_MUL_AY,
        ST_DIV_AY,
        ST_DIV_AY_W,
        ST_VEL,
        ST_SQ_VX,
        ST_SQ_VY,
        ST_MAG2,
        ST_CMP,
        ST_ROOT_M_W,
        ST_MUL_LX,
        ST_DIV_LX,
        ST_DIV_LX_W,
        ST_MUL_LY,
        ST_DIV_LY,
        ST_DIV_LY_W,
        ST_WRAP,
        ST_OUT
    } state_t;

endpackage

[rtl/pms_iter_unit.sv]
// pms_iter_unit: shared iterative square root and restoring divider
// one bit per cycle through one subtractor; depends on pms_pkg

module pms_iter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pms_pkg::eng_req_t             req,
    input  logic [pms_pkg::NUM_W-1:0]     num,
    input  logic [pms_pkg::DEN_W-1:0]     den,
    output pms_pkg::eng_rsp_t             rsp,
    output logic [pms_pkg::ROOT_W-1:0]    res
);

    logic                          busy_reg, busy_next;
    logic [pms_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    pms_pkg::eng_op_t              op_reg, op_next;
    logic [pms_pkg::NUM_W-1:0]     rem_reg, rem_next;
    logic [pms_pkg::AUX_W-1:0]     aux_reg, aux_next;
    logic [pms_pkg::SQ_W-1:0]      res_reg, res_next;
    logic                          ovf_reg, ovf_next;

    logic [pms_pkg::AUX_W-1:0]     cand;
    logic [pms_pkg::AUX_W-1:0]     rem_ext;
    logic [pms_pkg::AUX_W-1:0]     diff;
    logic [pms_pkg::AUX_W-1:0]     den_ext;
    logic                          ge;

    assign rem_ext = pms_pkg::AUX_W'(rem_reg);
    assign den_ext = pms_pkg::AUX_W'(den);
    assign cand    = (op_reg == pms_pkg::OP_SQRT) ?
                     pms_pkg::AUX_W'(res_reg) + aux_reg : aux_reg;
    assign ge      = rem_ext >= cand;
    assign diff    = rem_ext - cand;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        rem_next  = rem_reg;
        aux_next  = aux_reg;
        res_next  = res_reg;
        ovf_next  = ovf_reg;
        if (req.start)
        begin
            op_next   = req.op;
            busy_next = 1'b1;
            rem_next  = num;
            res_next  = '0;
            if (req.op == pms_pkg::OP_SQRT)
            begin
                aux_next = pms_pkg::AUX_W'(1) << (pms_pkg::SQ_W - 2);
                cnt_next = pms_pkg::CNT_W'(pms_pkg::ROOT_W - 1);
                ovf_next = 1'b0;
            end
            else
            begin
                aux_next = den_ext << (pms_pkg::QUO_W - 1);
                cnt_next = pms_pkg::CNT_W'(pms_pkg::QUO_W - 1);
                ovf_next = pms_pkg::AUX_W'(num) >= (den_ext << pms_pkg::QUO_W);
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == pms_pkg::OP_SQRT)
            begin
                if (ge)
                begin
                    rem_next = pms_pkg::NUM_W'(diff);
                    res_next = (res_reg >> 1) + aux_reg[pms_pkg::SQ_W-1:0];
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                aux_next = aux_reg >> 2;
            end
            else
            begin
                if (ge)
                begin
                    rem_next = pms_pkg::NUM_W'(diff);
                end
                res_next = {res_reg[pms_pkg::SQ_W-2:0], ge};
                aux_next = aux_reg >> 1;
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= pms_pkg::OP_SQRT;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        aux_reg <= aux_next;
        res_reg <= res_next;
        ovf_reg <= ovf_next;
    end

    assign rsp = '{busy: busy_reg, ovf: ovf_reg};
    assign res = res_reg[pms_pkg::ROOT_W-1:0];

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("unit not busy after start");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("start while busy");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg == '0 |=> !busy_reg)
        else $error("unit ran past last step");

endmodule

[rtl/particle_motion_step.sv]
// particle_motion_step: one frame tick of a wrapped, speed limited particle
// sequencer, config registers and shared multiplier; uses pms_pkg, pms_iter_unit
//
//   channel   direction  beat                                   handshake
//   apb       in/out     one register write or read             psel/penable, pready
//   in        in         ext_accel_x/y, target_x/y              in_valid/in_ready
//   out       out        pos_x/y, vel_x/y                       out_valid/out_ready
//
// a beat is shortest in constant and external modes; it takes longer when the
// speed limit acts, in seek mode and, longer again, in the scaled seek modes
// roots and divides keep the shared unit busy, and a wait state collects each result
// in_ready is high only while idle; a result waits in the output register
// rst_n clears configuration to defaults and the particle to mid screen, at rest

module particle_motion_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [17:0]            ext_accel_x,
    input  logic signed [17:0]            ext_accel_y,
    input  logic [11:0]                   target_x,
    input  logic [11:0]                   target_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [27:0]                   pos_x,
    output logic [27:0]                   pos_y,
    output logic signed [23:0]            vel_x,
    output logic signed [23:0]            vel_y
);

    pms_pkg::state_t state_reg, state_next;

    logic [11:0]        width_reg, width_next;
    logic [11:0]        height_reg, height_next;
    logic [22:0]        top_reg, top_next;
    logic [2:0]         mode_reg, mode_next;
    logic signed [17:0] cax_reg, cax_next;
    logic signed [17:0] cay_reg, cay_next;

    logic [pms_pkg::POS_W-1:0]         pos_x_reg, pos_x_next;
    logic [pms_pkg::POS_W-1:0]         pos_y_reg, pos_y_next;
    logic signed [pms_pkg::VEL_W-1:0]  vel_x_reg, vel_x_next;
    logic signed [pms_pkg::VEL_W-1:0]  vel_y_reg, vel_y_next;
    logic                              out_valid_reg, out_valid_next;

    logic signed [pms_pkg::DIFF_W-1:0] dx_reg, dx_next;
    logic signed [pms_pkg::DIFF_W-1:0] dy_reg, dy_next;
    logic [pms_pkg::SQ_W-1:0]          acc_reg, acc_next;
    logic [pms_pkg::PROD_W-1:0]        prod_reg, prod_next;
    logic [pms_pkg::ROOT_W-1:0]        root_reg, root_next;
    logic [pms_pkg::DENSUM_W-1:0]      densum_reg, densum_next;
    logic [pms_pkg::GAIN_W-1:0]        gain_reg, gain_next;
    logic signed [pms_pkg::ACC_W-1:0]  ax_reg, ax_next;
    logic signed [pms_pkg::ACC_W-1:0]  ay_reg, ay_next;
    logic signed [pms_pkg::VX_W-1:0]   vx_reg, vx_next;
    logic signed [pms_pkg::VX_W-1:0]   vy_reg, vy_next;
    logic [pms_pkg::POS_W-1:0]         opx_reg, opx_next;
    logic [pms_pkg::POS_W-1:0]         opy_reg, opy_next;
    logic signed [pms_pkg::VEL_W-1:0]  ovx_reg, ovx_next;
    logic signed [pms_pkg::VEL_W-1:0]  ovy_reg, ovy_next;

    logic [pms_pkg::MUL_W-1:0]         mul_a, mul_b;
    pms_pkg::eng_req_t                 eng_req;
    pms_pkg::eng_rsp_t                 eng_rsp;
    logic [pms_pkg::NUM_W-1:0]         eng_num;
    logic [pms_pkg::DEN_W-1:0]         eng_den;
    logic [pms_pkg::ROOT_W-1:0]        eng_res;

    logic signed [pms_pkg::DIFF_W-1:0] dx_neg, dy_neg;
    logic [pms_pkg::MUL_W-1:0]         abs_dx, abs_dy;
    logic signed [pms_pkg::VX_W-1:0]   vx_neg, vy_neg;
    logic [pms_pkg::MUL_W-1:0]         abs_vx, abs_vy;
    logic signed [pms_pkg::ACC_W-1:0]  q_acc;
    logic signed [pms_pkg::VX_W-1:0]   q_vel;
    logic [pms_pkg::GAIN_W-1:0]        gain_top, gain_sat;
    logic [pms_pkg::QUO_W-1:0]         quo;
    logic signed [pms_pkg::WRAP_W-1:0] sum_x, sum_y, lim_x, lim_y;
    logic                              cfg_write;

    function automatic logic [pms_pkg::POS_W-1:0] wrap_coord(
        input logic signed [pms_pkg::WRAP_W-1:0] p,
        input logic signed [pms_pkg::WRAP_W-1:0] lim
    );
        logic signed [pms_pkg::WRAP_W-1:0] r;
        r = p;
        if (r > lim)
        begin
            r = '0;
        end
        if (r < 0)
        begin
            r = lim;
        end
        return r[pms_pkg::POS_W-1:0];
    endfunction

    pms_iter_unit u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (eng_req),
        .num   (eng_num),
        .den   (eng_den),
        .rsp   (eng_rsp),
        .res   (eng_res)
    );

    // magnitudes for the unsigned multiplier
    assign dx_neg = -dx_reg;
    assign dy_neg = -dy_reg;
    assign abs_dx = dx_reg[pms_pkg::DIFF_W-1] ? dx_neg[pms_pkg::MUL_W-1:0]
                                               : dx_reg[pms_pkg::MUL_W-1:0];
    assign abs_dy = dy_reg[pms_pkg::DIFF_W-1] ? dy_neg[pms_pkg::MUL_W-1:0]
                                               : dy_reg[pms_pkg::MUL_W-1:0];
    assign vx_neg = -vx_reg;
    assign vy_neg = -vy_reg;
    assign abs_vx = pms_pkg::MUL_W'(vx_reg[pms_pkg::VX_W-1] ? vx_neg[pms_pkg::VEL_W-1:0]
                                                            : vx_reg[pms_pkg::VEL_W-1:0]);
    assign abs_vy = pms_pkg::MUL_W'(vy_reg[pms_pkg::VX_W-1] ? vy_neg[pms_pkg::VEL_W-1:0]
                                                            : vy_reg[pms_pkg::VEL_W-1:0]);

    assign q_acc = $signed({1'b0, eng_res[pms_pkg::GAIN_W-1:0]});
    assign q_vel = $signed({2'b00, eng_res[pms_pkg::QUO_W-1:0]});
    assign quo   = eng_res[pms_pkg::QUO_W-1:0];

    // gain saturation for the distance scaled seek modes
    assign gain_top = (mode_reg == pms_pkg::MODE_FAR) ? pms_pkg::GAIN_THREE
                                                      : pms_pkg::GAIN_TWO;
    assign gain_sat = (eng_rsp.ovf || quo > pms_pkg::QUO_W'(gain_top)) ? gain_top
                                                     : quo[pms_pkg::GAIN_W-1:0];

    assign sum_x = $signed({2'b00, pos_x_reg}) + pms_pkg::WRAP_W'(vx_reg);
    assign sum_y = $signed({2'b00, pos_y_reg}) + pms_pkg::WRAP_W'(vy_reg);
    assign lim_x = $signed({2'b00, width_reg, {pms_pkg::FRAC_BITS{1'b0}}});
    assign lim_y = $signed({2'b00, height_reg, {pms_pkg::FRAC_BITS{1'b0}}});

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        top_next    = top_reg;
        mode_next   = mode_reg;
        cax_next    = cax_reg;
        cay_next    = cay_reg;
        if (cfg_write)
        begin
            case (paddr[4:2])
                pms_pkg::REG_WIDTH:  width_next  = pwdata[11:0];
                pms_pkg::REG_HEIGHT: height_next = pwdata[11:0];
                pms_pkg::REG_TOP:    top_next    = pwdata[22:0];
                pms_pkg::REG_MODE:   mode_next   = pwdata[2:0];
                pms_pkg::REG_CAX:    cax_next    = $signed(pwdata[17:0]);
                pms_pkg::REG_CAY:    cay_next    = $signed(pwdata[17:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            pms_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            pms_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            pms_pkg::REG_TOP:    prdata = 32'(top_reg);
            pms_pkg::REG_MODE:   prdata = 32'(mode_reg);
            pms_pkg::REG_CAX:    prdata = 32'(cax_reg);
            pms_pkg::REG_CAY:    prdata = 32'(cay_reg);
            default:             prdata = '0;
        endcase
    end

    assign in_ready = (state_reg == pms_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        vel_x_next     = vel_x_reg;
        vel_y_next     = vel_y_reg;
        out_valid_next = out_valid_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        acc_next       = acc_reg;
        root_next      = root_reg;
        densum_next    = densum_reg;
        gain_next      = gain_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        opx_next       = opx_reg;
        opy_next       = opy_reg;
        ovx_next       = ovx_reg;
        ovy_next       = ovy_reg;
        mul_a          = '0;
        mul_b          = '0;
        eng_req        = '{start: 1'b0, op: pms_pkg::OP_SQRT};
        eng_num        = '0;
        eng_den        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            pms_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    dx_next = $signed({1'b0, target_x, {pms_pkg::FRAC_BITS{1'b0}}})
                              - $signed({1'b0, pos_x_reg});
                    dy_next = $signed({1'b0, target_y, {pms_pkg::FRAC_BITS{1'b0}}})
                              - $signed({1'b0, pos_y_reg});
                    case (mode_reg)
                        pms_pkg::MODE_CONST:
                        begin
                            ax_next    = pms_pkg::ACC_W'(cax_reg);
                            ay_next    = pms_pkg::ACC_W'(cay_reg);
                            state_next = pms_pkg::ST_VEL;
                        end
                        pms_pkg::MODE_EXT:
                        begin
                            ax_next    = pms_pkg::ACC_W'(ext_accel_x);
                            ay_next    = pms_pkg::ACC_W'(ext_accel_y);
                            state_next = pms_pkg::ST_VEL;
                        end
                        pms_pkg::MODE_SEEK, pms_pkg::MODE_FAR, pms_pkg::MODE_CLOSE:
                        begin
                            state_next = pms_pkg::ST_SQ_DX;
                        end
                        default:
                        begin
                            ax_next    = '0;
                            ay_next    = '0;
                            state_next = pms_pkg::ST_VEL;
                        end
                    endcase
                end
            end
            pms_pkg::ST_SQ_DX:
            begin
                mul_a      = abs_dx;
                mul_b      = abs_dx;
                state_next = pms_pkg::ST_SQ_DY;
            end
            pms_pkg::ST_SQ_DY:
            begin
                acc_next   = pms_pkg::SQ_W'(prod_reg);
                mul_a      = abs_dy;
                mul_b      = abs_dy;
                state_next = pms_pkg::ST_D2;
            end
            pms_pkg::ST_D2:
            begin
                acc_next   = acc_reg + pms_pkg::SQ_W'(prod_reg);
                state_next = pms_pkg::ST_ROOT_D;
            end
            pms_pkg::ST_ROOT_D:
            begin
                // target on the particle: no direction, no push
                if (acc_reg == '0)
                begin
                    ax_next    = '0;
                    ay_next    = '0;
                    state_next = pms_pkg::ST_VEL;
                end
                else
                begin
                    eng_req    = '{start: 1'b1, op: pms_pkg::OP_SQRT};
                    eng_num    = pms_pkg::NUM_W'(acc_reg);
                    state_next = pms_pkg::ST_ROOT_D_W;
                end
            end
            pms_pkg::ST_ROOT_D_W:
            begin
                if (!eng_rsp.busy)
                begin
                    root_next  = eng_res;
                    state_next = pms_pkg::ST_WW;
                end
            end
            pms_pkg::ST_WW:
            begin
                mul_a      = pms_pkg::MUL_W'(width_reg);
                mul_b      = pms_pkg::MUL_W'(width_reg);
                state_next = pms_pkg::ST_HH;
            end
            pms_pkg::ST_HH:
            begin
                densum_next = pms_pkg::DENSUM_W'(prod_reg);
                mul_a       = pms_pkg::MUL_W'(height_reg);
                mul_b       = pms_pkg::MUL_W'(height_reg);
                state_next  = pms_pkg::ST_DEN;
            end
            pms_pkg::ST_DEN:
            begin
                densum_next = densum_reg + pms_pkg::DENSUM_W'(prod_reg);
                if (mode_reg == pms_pkg::MODE_SEEK)
                begin
                    gain_next  = pms_pkg::GAIN_HALF;
                    state_next = pms_pkg::ST_MUL_AX;
                end
                else
                begin
                    state_next = pms_pkg::ST_RATIO;
                end
            end
            pms_pkg::ST_RATIO:
            begin
                eng_req = '{start: 1'b1, op: pms_pkg::OP_DIV};
                if (mode_reg == pms_pkg::MODE_FAR)
                begin
                    eng_num = (pms_pkg::NUM_W'(acc_reg) << 1) + pms_pkg::NUM_W'(acc_reg);
                end
                else
                begin
                    eng_num = pms_pkg::NUM_W'(acc_reg) << 1;
                end
                eng_den    = {densum_reg, {pms_pkg::FRAC_BITS{1'b0}}};
                state_next = pms_pkg::ST_RATIO_W;
            end
            pms_pkg::ST_RATIO_W:
            begin
                if (!eng_rsp.busy)
                begin
                    gain_next  = (mode_reg == pms_pkg::MODE_FAR) ? gain_sat
                                                                 : pms_pkg::GAIN_TWO - gain_sat;
                    state_next = pms_pkg::ST_MUL_AX;
                end
            end
            pms_pkg::ST_MUL_AX:
            begin
                mul_a      = abs_dx;
                mul_b      = pms_pkg::MUL_W'(gain_reg);
                state_next = pms_pkg::ST_DIV_AX;
            end
            pms_pkg::ST_DIV_AX:
            begin
                eng_req    = '{start: 1'b1, op: pms_pkg::OP_DIV};
                eng_num    = pms_pkg::NUM_W'(prod_reg);
                eng_den    = pms_pkg::DEN_W'(root_reg);
                state_next = pms_pkg::ST_DIV_AX_W;
            end
            pms_pkg::ST_DIV_AX_W:
            begin
                if (!eng_rsp.busy)
                begin
                    ax_next    = dx_reg[pms_pkg::DIFF_W-1] ? -q_acc : q_acc;
                    state_next = pms_pkg::ST_MUL_AY;
                end
            end
            pms_pkg::ST_MUL_AY:
            begin
                mul_a      = abs_dy;
                mul_b      = pms_pkg::MUL_W'(gain_reg);
                state_next = pms_pkg::ST_DIV_AY;
            end
            pms_pkg::ST_DIV_AY:
            begin
                eng_req    = '{start: 1'b1, op: pms_pkg::OP_DIV};
                eng_num    = pms_pkg::NUM_W'(prod_reg);
                eng_den    = pms_pkg::DEN_W'(root_reg);
                state_next = pms_pkg::ST_DIV_AY_W;
            end
            pms_pkg::ST_DIV_AY_W:
            begin
                if (!eng_rsp.busy)
                begin
                    ay_next    = dy_reg[pms_pkg::DIFF_W-1] ? -q_acc : q_acc;
                    state_next = pms_pkg::ST_VEL;
                end
            end
            pms_pkg::ST_VEL:
            begin
                vx_next    = pms_pkg::VX_W'(vel_x_reg) + pms_pkg::VX_W'(ax_reg);
                vy_next    = pms_pkg::VX_W'(vel_y_reg) + pms_pkg::VX_W'(ay_reg);
                state_next = pms_pkg::ST_SQ_VX;
            end
            pms_pkg::ST_SQ_VX:
            begin
                mul_a      = abs_vx;
                mul_b      = abs_vx;
                state_next = pms_pkg::ST_SQ_VY;
            end
            pms_pkg::ST_SQ_VY:
            begin
                acc_next   = pms_pkg::SQ_W'(prod_reg);
                mul_a      = abs_vy;
                mul_b      = abs_vy;
                state_next = pms_pkg::ST_MAG2;
            end
            pms_pkg::ST_MAG2:
            begin
                acc_next   = acc_reg + pms_pkg::SQ_W'(prod_reg);
                mul_a      = pms_pkg::MUL_W'(top_reg);
                mul_b      = pms_pkg::MUL_W'(top_reg);
                state_next = pms_pkg::ST_CMP;
            end
            pms_pkg::ST_CMP:
            begin
                if (acc_reg > pms_pkg::SQ_W'(prod_reg))
                begin
                    eng_req    = '{start: 1'b1, op: pms_pkg::OP_SQRT};
                    eng_num    = pms_pkg::NUM_W'(acc_reg);
                    state_next = pms_pkg::ST_ROOT_M_W;
                end
                else
                begin
                    state_next = pms_pkg::ST_WRAP;
                end
            end
            pms_pkg::ST_ROOT_M_W:
            begin
                if (!eng_rsp.busy)
                begin
                    root_next  = eng_res;
                    state_next = pms_pkg::ST_MUL_LX;
                end
            end
            pms_pkg::ST_MUL_LX:
            begin
                mul_a      = abs_vx;
                mul_b      = pms_pkg::MUL_W'(top_reg);
                state_next = pms_pkg::ST_DIV_LX;
            end
            pms_pkg::ST_DIV_LX:
            begin
                eng_req    = '{start: 1'b1, op: pms_pkg::OP_DIV};
                eng_num    = pms_pkg::NUM_W'(prod_reg);
                eng_den    = pms_pkg::DEN_W'(root_reg);
                state_next = pms_pkg::ST_DIV_LX_W;
            end
            pms_pkg::ST_DIV_LX_W:
            begin
                if (!eng_rsp.busy)
                begin
                    vx_next    = vx_reg[pms_pkg::VX_W-1] ? -q_vel : q_vel;
                    state_next = pms_pkg::ST_MUL_LY;
                end
            end
            pms_pkg::ST_MUL_LY:
            begin
                mul_a      = abs_vy;
                mul_b      = pms_pkg::MUL_W'(top_reg);
                state_next = pms_pkg::ST_DIV_LY;
            end
            pms_pkg::ST_DIV_LY:
            begin
                eng_req    = '{start: 1'b1, op: pms_pkg::OP_DIV};
                eng_num    = pms_pkg::NUM_W'(prod_reg);
                eng_den    = pms_pkg::DEN_W'(root_reg);
                state_next = pms_pkg::ST_DIV_LY_W;
            end
            pms_pkg::ST_DIV_LY_W:
            begin
                if (!eng_rsp.busy)
                begin
                    vy_next    = vy_reg[pms_pkg::VX_W-1] ? -q_vel : q_vel;
                    state_next = pms_pkg::ST_WRAP;
                end
            end
            pms_pkg::ST_WRAP:
            begin
                vel_x_next = vx_reg[pms_pkg::VEL_W-1:0];
                vel_y_next = vy_reg[pms_pkg::VEL_W-1:0];
                pos_x_next = wrap_coord(sum_x, lim_x);
                pos_y_next = wrap_coord(sum_y, lim_y);
                state_next = pms_pkg::ST_OUT;
            end
            pms_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    opx_next       = pos_x_reg;
                    opy_next       = pos_y_reg;
                    ovx_next       = vel_x_reg;
                    ovy_next       = vel_y_reg;
                    out_valid_next = 1'b1;
                    state_next     = pms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pms_pkg::ST_IDLE;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pms_pkg::ST_IDLE;
            width_reg     <= pms_pkg::WIDTH_RST;
            height_reg    <= pms_pkg::HEIGHT_RST;
            top_reg       <= pms_pkg::TOP_RST;
            mode_reg      <= pms_pkg::MODE_CONST;
            cax_reg       <= $signed(pms_pkg::CAX_RST);
            cay_reg       <= $signed(pms_pkg::CAY_RST);
            pos_x_reg     <= pms_pkg::POS_X_RST;
            pos_y_reg     <= pms_pkg::POS_Y_RST;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            top_reg       <= top_next;
            mode_reg      <= mode_next;
            cax_reg       <= cax_next;
            cay_reg       <= cay_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            vel_x_reg     <= vel_x_next;
            vel_y_reg     <= vel_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        root_reg   <= root_next;
        densum_reg <= densum_next;
        gain_reg   <= gain_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        opx_reg    <= opx_next;
        opy_reg    <= opy_next;
        ovx_reg    <= ovx_next;
        ovy_reg    <= ovy_next;
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = opx_reg;
    assign pos_y     = opy_reg;
    assign vel_x     = ovx_reg;
    assign vel_y     = ovy_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("still ready after accepting a beat");

    a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pms_pkg::ST_IDLE |-> !eng_rsp.busy)
        else $error("iterative unit busy while idle");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_x_reg <= pms_pkg::POS_MAX && pos_y_reg <= pms_pkg::POS_MAX)
        else $error("position beyond screen range");

endmodule

[bench/pms_checker.sv]
`timescale 1ns / 1ps
// pms_checker: watches the register port and both beat channels of
// particle_motion_step, predicts each motion step and compares the results
// depends on pms_pkg for register and mode codes
module pms_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [17:0] ext_accel_x,
    input  logic signed [17:0] ext_accel_y,
    input  logic [11:0]        target_x,
    input  logic [11:0]        target_y,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [27:0]        pos_x,
    input  logic [27:0]        pos_y,
    input  logic [23:0]        vel_x,
    input  logic [23:0]        vel_y,
    output int                 pending,
    output int                 errors
);

    typedef struct {
        logic [27:0] px;
        logic [27:0] py;
        logic [23:0] vx;
        logic [23:0] vy;
    } motion_t;

    motion_t motion_q[$];

    longint scr_w, scr_h, speed_cap, cax, cay;
    logic [2:0] mode;
    longint part_x, part_y, part_vx, part_vy;

    function automatic longint floor_root(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v)
            b = b >>> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint clamp_ratio(longint num, longint den, longint top);
        longint q;
        if (den == 0)
            return (num == 0) ? 0 : top;
        q = num / den;
        return (q > top) ? top : q;
    endfunction

    function automatic longint wrap_to(longint p, longint size);
        longint lim;
        lim = size <<< pms_pkg::FRAC_BITS;
        if (p > lim)
            p = 0;
        if (p < 0)
            p = lim;
        return p;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            pms_pkg::REG_WIDTH:  scr_w = longint'(val[11:0]);
            pms_pkg::REG_HEIGHT: scr_h = longint'(val[11:0]);
            pms_pkg::REG_TOP:    speed_cap = longint'(val[22:0]);
            pms_pkg::REG_MODE:   mode = val[2:0];
            pms_pkg::REG_CAX:    cax = longint'($signed(val[17:0]));
            pms_pkg::REG_CAY:    cay = longint'($signed(val[17:0]));
            default: ;
        endcase
    endtask

    task automatic advance(output motion_t res);
        longint ax, ay, vx, vy, dx, dy, d2, d, den, gain, mag;
        ax = 0;
        ay = 0;
        if (mode == pms_pkg::MODE_CONST)
        begin
            ax = cax;
            ay = cay;
        end
        else if (mode == pms_pkg::MODE_EXT)
        begin
            ax = longint'(ext_accel_x);
            ay = longint'(ext_accel_y);
        end
        else if (mode == pms_pkg::MODE_SEEK || mode == pms_pkg::MODE_FAR ||
                 mode == pms_pkg::MODE_CLOSE)
        begin
            dx = (longint'(target_x) <<< pms_pkg::FRAC_BITS) - part_x;
            dy = (longint'(target_y) <<< pms_pkg::FRAC_BITS) - part_y;
            d2 = dx * dx + dy * dy;
            d = floor_root(d2);
            den = (scr_w * scr_w + scr_h * scr_h) <<< pms_pkg::FRAC_BITS;
            if (mode == pms_pkg::MODE_SEEK)
                gain = 64'sd1 <<< (pms_pkg::FRAC_BITS - 1);
            else if (mode == pms_pkg::MODE_FAR)
                gain = clamp_ratio(3 * d2, den, 64'sd3 <<< pms_pkg::FRAC_BITS);
            else
                gain = (64'sd2 <<< pms_pkg::FRAC_BITS) -
                       clamp_ratio(2 * d2, den, 64'sd2 <<< pms_pkg::FRAC_BITS);
            if (d != 0)
            begin
                ax = (dx * gain) / d;
                ay = (dy * gain) / d;
            end
        end
        vx = part_vx + ax;
        vy = part_vy + ay;
        if (vx * vx + vy * vy > speed_cap * speed_cap)
        begin
            mag = floor_root(vx * vx + vy * vy);
            vx = (vx * speed_cap) / mag;
            vy = (vy * speed_cap) / mag;
        end
        part_vx = vx;
        part_vy = vy;
        part_x = wrap_to(part_x + vx, scr_w);
        part_y = wrap_to(part_y + vy, scr_h);
        res.px = part_x[27:0];
        res.py = part_y[27:0];
        res.vx = part_vx[23:0];
        res.vy = part_vy[23:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        motion_t e;
        if (!rst_n)
        begin
            scr_w = 1024;
            scr_h = 768;
            speed_cap = 655360;
            mode = pms_pkg::MODE_CONST;
            cax = -66;
            cay = 655;
            part_x = 64'sd512 <<< pms_pkg::FRAC_BITS;
            part_y = 64'sd384 <<< pms_pkg::FRAC_BITS;
            part_vx = 0;
            part_vy = 0;
            motion_q.delete();
            pending <= 0;
            errors <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                write_reg(paddr[4:2], pwdata);
            if (out_valid && out_ready)
            begin
                if (motion_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors <= errors + 1;
                end
                else
                begin
                    e = motion_q.pop_front();
                    if (pos_x !== e.px || pos_y !== e.py || vel_x !== e.vx || vel_y !== e.vy)
                        errors <= errors + 1;
                    if (pos_x !== e.px)
                        $error("pos_x expected %0h got %0h", e.px, pos_x);
                    if (pos_y !== e.py)
                        $error("pos_y expected %0h got %0h", e.py, pos_y);
                    if (vel_x !== e.vx)
                        $error("vel_x expected %0h got %0h", e.vx, vel_x);
                    if (vel_y !== e.vy)
                        $error("vel_y expected %0h got %0h", e.vy, vel_y);
                end
            end
            if (in_valid && in_ready)
            begin
                advance(e);
                motion_q.push_back(e);
            end
            pending <= motion_q.size();
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for particle_motion_step
// depends on pms_pkg, particle_motion_step and pms_checker
module tb_top;

    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam int STALL_LIMIT = 20000;

    logic clk, rst_n;
    logic psel, penable, pwrite, pready;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [17:0] ext_accel_x, ext_accel_y;
    logic [11:0] target_x, target_y;
    logic [27:0] pos_x, pos_y;
    logic signed [23:0] vel_x, vel_y;
    int pending, errors;
    int send_idle, recv_idle, hold_cycles, quiet;

    particle_motion_step u_top (.*);

    pms_checker u_chk (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready), .in_valid(in_valid),
        .in_ready(in_ready), .ext_accel_x(ext_accel_x), .ext_accel_y(ext_accel_y),
        .target_x(target_x), .target_y(target_y), .out_valid(out_valid),
        .out_ready(out_ready), .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x),
        .vel_y(vel_y), .pending(pending), .errors(errors)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic send_tick(logic [17:0] ex, logic [17:0] ey, logic [11:0] tx, logic [11:0] ty);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ext_accel_x <= ex;
        ext_accel_y <= ey;
        target_x <= tx;
        target_y <= ty;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_random(int n);
        logic [17:0] ex, ey;
        repeat (n)
        begin
            if ($urandom_range(9) == 0)
            begin
                ex = 18'($urandom);
                ey = 18'($urandom);
            end
            else
            begin
                ex = 18'($signed($urandom_range(131072)) - 65536);
                ey = 18'($signed($urandom_range(131072)) - 65536);
            end
            send_tick(ex, ey, 12'($urandom), 12'($urandom));
        end
        in_valid <= 1'b0;
    endtask

    task automatic pick_config(int k);
        int w, h;
        drain();
        case ($urandom_range(3))
            0: begin w = 1; h = 1; end
            1: begin w = 4095; h = 4095; end
            default: begin w = $urandom_range(1, 4095); h = $urandom_range(1, 4095); end
        endcase
        reg_write(pms_pkg::REG_WIDTH, w);
        reg_write(pms_pkg::REG_HEIGHT, h);
        case ($urandom_range(3))
            0: reg_write(pms_pkg::REG_TOP, 0);
            1: reg_write(pms_pkg::REG_TOP, 32'h7FFFFF);
            default: reg_write(pms_pkg::REG_TOP, $urandom_range(4194304));
        endcase
        reg_write(pms_pkg::REG_MODE, k % 8);
        if ($urandom_range(3) == 0)
        begin
            reg_write(pms_pkg::REG_CAX, $urandom);
            reg_write(pms_pkg::REG_CAY, $urandom);
        end
        else
        begin
            reg_write(pms_pkg::REG_CAX, $urandom_range(131072) - 65536);
            reg_write(pms_pkg::REG_CAY, $urandom_range(131072) - 65536);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; out_ready = 1'b0;
        ext_accel_x = '0; ext_accel_y = '0; target_x = '0; target_y = '0;
        send_idle = 0; recv_idle = 0; hold_cycles = 0; quiet = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults, then seek mode with targets at mid screen, zero and the maximum
        send_tick(0, 0, 0, 0);
        in_valid <= 1'b0;
        drain();
        reg_write(pms_pkg::REG_MODE, pms_pkg::MODE_SEEK);
        reg_write(REG_SPARE_A, 32'hFFFF_FFFF);
        reg_write(REG_SPARE_B, 32'h1234_5678);
        send_tick(0, 0, 12'd512, 12'd384);
        send_tick(0, 0, 12'd0, 12'd0);
        send_tick(0, 0, 12'd4095, 12'd4095);
        in_valid <= 1'b0;
        drain();
        reg_write(pms_pkg::REG_MODE, pms_pkg::MODE_EXT);
        send_tick(18'sd65536, -18'sd65536, 0, 0);
        send_tick(-18'sd65536, 18'sd65536, 0, 0);
        send_tick(18'h1FFFF, 18'h20000, 12'hFFF, 12'hFFF);
        send_tick(18'h3FFFF, 18'h0, 0, 0);
        in_valid <= 1'b0;
        drain();
        // zero screen size with both distance-scaled modes
        reg_write(pms_pkg::REG_WIDTH, 0);
        reg_write(pms_pkg::REG_HEIGHT, 0);
        reg_write(pms_pkg::REG_MODE, pms_pkg::MODE_FAR);
        send_tick(0, 0, 12'd100, 12'd3000);
        send_tick(0, 0, 12'd0, 12'd0);
        in_valid <= 1'b0;
        drain();
        reg_write(pms_pkg::REG_MODE, pms_pkg::MODE_CLOSE);
        send_tick(0, 0, 12'd4000, 12'd7);
        send_tick(0, 0, 12'd0, 12'd0);
        in_valid <= 1'b0;
        for (int m = 5; m < 8; m++)
        begin
            drain();
            reg_write(pms_pkg::REG_MODE, m);
            send_tick(18'sd1000, 18'sd1000, 12'd10, 12'd10);
            in_valid <= 1'b0;
        end
        drain();
        reg_write(pms_pkg::REG_WIDTH, 4095);
        reg_write(pms_pkg::REG_HEIGHT, 4095);
        reg_write(pms_pkg::REG_TOP, 32'h7FFFFF);
        reg_write(pms_pkg::REG_MODE, pms_pkg::MODE_CONST);
        reg_write(pms_pkg::REG_CAX, 32'h1FFFF);
        reg_write(pms_pkg::REG_CAY, 32'h20000);
        send_random(3);
        drain();
        reg_write(pms_pkg::REG_TOP, 0);
        send_random(2);

        for (int r = 0; r < 3; r++)
        begin
            send_idle = (r == 0) ? 27 : (r == 1) ? 66 : 0;
            recv_idle = (r == 0) ? 66 : (r == 1) ? 27 : 0;
            for (int k = 0; k < 8; k++)
            begin
                pick_config(k + r);
                if (r == 2 && k == 3)
                    hold_cycles = 600;
                send_random(52);
            end
        end

        drain();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[sim.f]
rtl/pms_pkg.sv
rtl/pms_iter_unit.sv
rtl/particle_motion_step.sv
bench/pms_checker.sv
bench/tb_top.sv
